// ===== hdl/sensor_scale_average_minmax_top_defines.svh =====
// Assertion macros for the sensor scaling / averaging block.
// Included by the top level; needs no other file.
`ifndef SENSOR_SCALE_AVERAGE_MINMAX_TOP_DEFINES_SVH
`define SENSOR_SCALE_AVERAGE_MINMAX_TOP_DEFINES_SVH
`ifndef SYNTH
`define SSAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssam assertion failed");
`define SSAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssam assertion failed");
`else
`define SSAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/ssam_pkg.sv =====
// Shared constants, codes and types for the sensor scaling / averaging block.
// No dependencies.
package ssam_pkg;

    localparam int RAW_W      = 10;                 // converter reading
    localparam int Q_W        = 24;                 // Q15.8 value
    localparam int TALLY_W    = 32;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int WLEN_W     = 5;                  // window_length register
    localparam int MAX_WINDOW = 16;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = Q_W + IDX_W;
    localparam int DIFF_W     = Q_W + 1;
    localparam int PROD_W     = RAW_W + Q_W;        // |raw * diff|
    localparam int DVD_W      = PROD_W;
    localparam int DSR_W      = RAW_W;              // holds 1023 and any length
    localparam int STEP_W     = $clog2(DVD_W + 1);
    localparam int MUL_CNT_W  = $clog2(RAW_W + 1);
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 4 * Q_W + TALLY_W;

    localparam logic [DSR_W-1:0]      SCALE_DIV = DSR_W'(1023);
    localparam logic signed [Q_W-1:0] SENT_HI   = Q_W'(2559974);
    localparam logic signed [Q_W-1:0] SENT_LO   = Q_W'(-2559974);
    localparam logic signed [Q_W-1:0] Q_MAX     = Q_W'(8388607);
    localparam logic signed [Q_W-1:0] Q_MIN     = Q_W'(-8388608);

    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = 2'd2;

    typedef enum logic [1:0] {
        FUNC_FILTER = 2'd0,
        FUNC_SCALE  = 2'd1,
        FUNC_PRIME  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse, result register valid
    } t_unit_sts;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

// ===== hdl/ssam_mul.sv =====
// Bit-serial unsigned multiplier: one multiplier bit per cycle, MSB first.
// Depends on ssam_pkg.
module ssam_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ssam_pkg::Q_W-1:0]     i_mcand,
    input  logic [ssam_pkg::RAW_W-1:0]   i_mplier,
    output ssam_pkg::t_unit_sts          o_sts,
    output logic [ssam_pkg::PROD_W-1:0]  o_product
);

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [ssam_pkg::MUL_CNT_W-1:0]     r_cnt, n_cnt;
    logic [ssam_pkg::Q_W-1:0]           r_mcand, n_mcand;
    logic [ssam_pkg::RAW_W-1:0]         r_mpl, n_mpl;
    logic [ssam_pkg::PROD_W-1:0]        r_acc, n_acc;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_mcand = r_mcand;
        n_mpl   = r_mpl;
        n_acc   = r_acc;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = ssam_pkg::MUL_CNT_W'(ssam_pkg::RAW_W);
            n_mcand = i_mcand;
            n_mpl   = i_mplier;
            n_acc   = '0;
        end else if (r_busy) begin
            n_acc = {r_acc[ssam_pkg::PROD_W-2:0], 1'b0}
                  + (r_mpl[ssam_pkg::RAW_W-1] ? ssam_pkg::PROD_W'(r_mcand)
                                              : ssam_pkg::PROD_W'(0));
            n_mpl = {r_mpl[ssam_pkg::RAW_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ssam_pkg::MUL_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mcand <= n_mcand;
        r_mpl   <= n_mpl;
        r_acc   <= n_acc;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_product  = r_acc;

endmodule

// ===== hdl/ssam_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle; the dividend is
// left aligned and the step count says how many of its bits are used.
// Depends on ssam_pkg.
module ssam_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssam_pkg::t_div_req           i_req,
    input  logic [ssam_pkg::DVD_W-1:0]   i_dividend,
    input  logic [ssam_pkg::DSR_W-1:0]   i_divisor,
    output ssam_pkg::t_unit_sts          o_sts,
    output logic [ssam_pkg::Q_W-1:0]     o_quotient
);

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [ssam_pkg::STEP_W-1:0]        r_cnt, n_cnt;
    logic [ssam_pkg::DVD_W-1:0]         r_dvd, n_dvd;
    logic [ssam_pkg::DSR_W-1:0]         r_dsr, n_dsr;
    logic [ssam_pkg::DSR_W-1:0]         r_rem, n_rem;
    logic [ssam_pkg::Q_W-1:0]           r_quo, n_quo;
    logic [ssam_pkg::DSR_W:0]           trial;
    logic                               fits;

    assign trial = {r_rem, r_dvd[ssam_pkg::DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            // partial remainder stays below the divisor, so DSR_W bits suffice
            n_rem = fits ? ssam_pkg::DSR_W'(trial - {1'b0, r_dsr})
                         : trial[ssam_pkg::DSR_W-1:0];
            n_dvd = {r_dvd[ssam_pkg::DVD_W-2:0], 1'b0};
            n_quo = {r_quo[ssam_pkg::Q_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ssam_pkg::STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/sensor_scale_average_minmax_top.sv =====
// Sensor scaling, moving average and min/max tracking, top level.
// Depends on ssam_pkg, ssam_mul, ssam_div and the defines header.
//
// One request is worked on at a time. A request other than a min/max reset
// scales raw to out_min + raw*(out_max-out_min)/1023 with a bit-serial
// multiply and a one-bit-per-cycle divide. A scale-only or prime result is
// loaded after the divide, via the apply and done states; a min/max reset
// result goes straight to the done state. A filtered request with window
// length L above 1 then sums the window one entry per cycle and divides by
// L bit-serially. Loading waits while the previous result still sits unread
// in the output register. Once the result is loaded, the next request is
// accepted while it waits to be taken. The user must write configuration
// only while no request is in flight; the block itself does not enforce it.
`include "sensor_scale_average_minmax_top_defines.svh"
module sensor_scale_average_minmax_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ssam_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ssam_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // raw_sample[9:0], zero pad [15:10]
    input  logic [ssam_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [ssam_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // scaled_value[23:0], filtered_value[47:24], min_seen[71:48],
    // max_seen[95:72], samples_taken[127:96]
    output logic [ssam_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int Q_W    = ssam_pkg::Q_W;
    localparam int SUM_W  = ssam_pkg::SUM_W;
    localparam int IDX_W  = ssam_pkg::IDX_W;
    localparam int LEN_W  = ssam_pkg::LEN_W;
    localparam int DIFF_W = ssam_pkg::DIFF_W;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_MUL       = 8'b0000_0010,
        ST_DIV_SCALE = 8'b0000_0100,
        ST_APPLY     = 8'b0000_1000,
        ST_SUM       = 8'b0001_0000,
        ST_AVG_GO    = 8'b0010_0000,
        ST_DIV_AVG   = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } t_state;

    // configuration
    logic signed [Q_W-1:0]               r_out_min, r_out_max;
    logic [ssam_pkg::WLEN_W-1:0]         r_win_len;

    // control and datapath
    t_state                              r_state, n_state;
    ssam_pkg::t_func                     r_func, n_func;
    logic [ssam_pkg::RAW_W-1:0]          r_raw, n_raw;
    logic                                r_neg, n_neg;
    logic signed [Q_W-1:0]               r_scaled, n_scaled;
    logic signed [Q_W-1:0]               r_filt, n_filt;
    logic signed [Q_W-1:0]               r_low, n_low;
    logic signed [Q_W-1:0]               r_high, n_high;
    logic [ssam_pkg::TALLY_W-1:0]        r_tally, n_tally;
    logic [IDX_W-1:0]                    r_pos, n_pos;
    logic [LEN_W-1:0]                    r_cnt, n_cnt;
    logic signed [SUM_W-1:0]             r_sum, n_sum;
    logic signed [Q_W-1:0]               r_store [ssam_pkg::MAX_WINDOW];
    logic                                r_m_valid, n_m_valid;
    logic [ssam_pkg::OUT_TDATA_W-1:0]    r_m_data, n_m_data;

    logic                                accept;
    logic [LEN_W-1:0]                    eff_len;
    logic signed [DIFF_W-1:0]            diff;
    logic [Q_W-1:0]                      diff_mag;
    logic                                mul_start;
    ssam_pkg::t_unit_sts                 mul_sts, div_sts;
    logic [ssam_pkg::PROD_W-1:0]         product;
    ssam_pkg::t_div_req                  div_req;
    logic [ssam_pkg::DVD_W-1:0]          div_dvd;
    logic [ssam_pkg::DSR_W-1:0]          div_dsr;
    logic [Q_W-1:0]                      quotient;
    logic signed [Q_W+1:0]               q_ext, v_ext;
    logic signed [Q_W-1:0]               v_sat;
    logic [SUM_W-1:0]                    sum_mag;
    logic signed [SUM_W-1:0]             entry;
    logic [IDX_W-1:0]                    wr_pos, pos_next;
    logic [LEN_W-1:0]                    pos_inc;
    logic                                store_wr, store_prime;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_min <= '0;
            r_out_max <= Q_W'(261888);
            r_win_len <= ssam_pkg::WLEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssam_pkg::REG_OUT_MIN: r_out_min <= i_cfg_data[Q_W-1:0];
                ssam_pkg::REG_OUT_MAX: r_out_max <= i_cfg_data[Q_W-1:0];
                ssam_pkg::REG_WIN_LEN: r_win_len <= i_cfg_data[ssam_pkg::WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_win_len == '0)
            eff_len = LEN_W'(1);
        else if (int'(r_win_len) > ssam_pkg::MAX_WINDOW)
            eff_len = LEN_W'(ssam_pkg::MAX_WINDOW);
        else
            eff_len = LEN_W'(r_win_len);
    end

    assign diff     = DIFF_W'(r_out_max) - DIFF_W'(r_out_min);
    assign diff_mag = diff[DIFF_W-1] ? Q_W'(-diff) : diff[Q_W-1:0];

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // signed quotient, offset and saturation to Q15.8
    assign q_ext = r_neg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    assign v_ext = (Q_W+2)'(r_out_min) + q_ext;
    always_comb begin
        if (v_ext[Q_W+1:Q_W-1] == 3'b000 || v_ext[Q_W+1:Q_W-1] == 3'b111)
            v_sat = v_ext[Q_W-1:0];
        else if (v_ext[Q_W+1])
            v_sat = ssam_pkg::Q_MIN;
        else
            v_sat = ssam_pkg::Q_MAX;
    end

    assign sum_mag = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign entry   = SUM_W'(r_store[r_cnt[IDX_W-1:0]]);

    // a stale ring position after a length change writes entry 0
    assign wr_pos   = (LEN_W'(r_pos) >= eff_len) ? '0 : r_pos;
    assign pos_inc  = LEN_W'(wr_pos) + LEN_W'(1);
    assign pos_next = (pos_inc == eff_len) ? '0 : IDX_W'(pos_inc);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_raw       = r_raw;
        n_neg       = r_neg;
        n_scaled    = r_scaled;
        n_filt      = r_filt;
        n_low       = r_low;
        n_high      = r_high;
        n_tally     = r_tally;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_data    = r_m_data;
        store_wr    = 1'b0;
        store_prime = 1'b0;
        mul_start   = 1'b0;
        div_req     = '0;
        div_dvd     = product;
        div_dsr     = ssam_pkg::SCALE_DIV;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_func = ssam_pkg::t_func'(s_axis_tuser);
                    n_raw  = s_axis_tdata[ssam_pkg::RAW_W-1:0];
                    n_neg  = diff[DIFF_W-1];
                    if (ssam_pkg::t_func'(s_axis_tuser) == ssam_pkg::FUNC_CLEAR) begin
                        n_low    = ssam_pkg::SENT_HI;
                        n_high   = ssam_pkg::SENT_LO;
                        n_tally  = '0;
                        n_scaled = '0;
                        n_filt   = '0;
                        n_state  = ST_DONE;
                    end else begin
                        mul_start = 1'b1;
                        n_state   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mul_sts.done) begin
                    div_req.start = 1'b1;
                    div_req.steps = ssam_pkg::STEP_W'(ssam_pkg::DVD_W);
                    n_state       = ST_DIV_SCALE;
                end
            end
            ST_DIV_SCALE: begin
                if (div_sts.done) begin
                    n_scaled = v_sat;
                    n_state  = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_filt  = r_scaled;
                n_state = ST_DONE;
                case (r_func)
                    ssam_pkg::FUNC_PRIME: begin
                        store_prime = 1'b1;
                        n_low       = r_scaled;
                        n_high      = r_scaled;
                        n_tally     = '0;
                    end
                    ssam_pkg::FUNC_SCALE, ssam_pkg::FUNC_FILTER: begin
                        n_tally = r_tally + 1'b1;
                        n_low   = (r_scaled < r_low) ? r_scaled : r_low;
                        n_high  = (r_scaled > r_high) ? r_scaled : r_high;
                        if (r_func == ssam_pkg::FUNC_FILTER && eff_len > LEN_W'(1)) begin
                            store_wr = 1'b1;
                            n_pos    = pos_next;
                            n_cnt    = '0;
                            n_sum    = '0;
                            n_state  = ST_SUM;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SUM: begin
                // one window entry per cycle, entries 0 .. length-1
                n_sum = r_sum + entry;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == eff_len - LEN_W'(1))
                    n_state = ST_AVG_GO;
            end
            ST_AVG_GO: begin
                div_req.start = 1'b1;
                div_req.steps = ssam_pkg::STEP_W'(SUM_W);
                div_dvd       = {sum_mag, {(ssam_pkg::DVD_W - SUM_W){1'b0}}};
                div_dsr       = ssam_pkg::DSR_W'(eff_len);
                n_neg         = r_sum[SUM_W-1];
                n_state       = ST_DIV_AVG;
            end
            ST_DIV_AVG: begin
                if (div_sts.done) begin
                    n_filt  = r_neg ? Q_W'(-quotient) : quotient;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_tally, r_high, r_low, r_filt, r_scaled};
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_low     <= ssam_pkg::SENT_HI;
            r_high    <= ssam_pkg::SENT_LO;
            r_tally   <= '0;
            r_pos     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_low     <= n_low;
            r_high    <= n_high;
            r_tally   <= n_tally;
            r_pos     <= n_pos;
            r_m_valid <= n_m_valid;
        end
        r_func   <= n_func;
        r_raw    <= n_raw;
        r_neg    <= n_neg;
        r_scaled <= n_scaled;
        r_filt   <= n_filt;
        r_cnt    <= n_cnt;
        r_sum    <= n_sum;
        r_m_data <= n_m_data;
    end

    // window store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssam_pkg::MAX_WINDOW; i++)
                r_store[i] <= '0;
        end else if (store_prime) begin
            for (int i = 0; i < ssam_pkg::MAX_WINDOW; i++)
                r_store[i] <= r_scaled;
        end else if (store_wr) begin
            r_store[wr_pos] <= r_scaled;
        end
    end

    ssam_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (diff_mag),
        .i_mplier  (n_raw),
        .o_sts     (mul_sts),
        .o_product (product)
    );

    ssam_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_sts      (div_sts),
        .o_quotient (quotient)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `SSAM_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SSAM_ASSERT_IMP(a_mul_owner, i_clk, i_rst_n, mul_sts.busy, r_state == ST_MUL)
    `SSAM_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, div_sts.busy, (r_state == ST_DIV_SCALE) || (r_state == ST_DIV_AVG))

endmodule
